>>> rtl/rsi_pkg.sv
`default_nettype none
package rsi_pkg;

  typedef logic signed [31:0] q32_t;
  typedef logic signed [17:0] dir_t;

  // status codes
  localparam logic [1:0] ST_MISS   = 2'd0;
  localparam logic [1:0] ST_HIT    = 2'd1;
  localparam logic [1:0] ST_BEHIND = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_CENTER_X   = 3'd0;
  localparam logic [2:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [2:0] CFG_CENTER_Z   = 3'd2;
  localparam logic [2:0] CFG_RADIUS_SQ  = 3'd3;
  localparam logic [2:0] CFG_RADIUS_INV = 3'd4;
  localparam logic [2:0] CFG_EPSILON    = 3'd5;
  localparam logic [2:0] CFG_FAR        = 3'd6;

  localparam int SqrtStages = 16;

  // one square root step carries the ray along
  typedef struct packed {
    logic [63:0]      rad;
    logic [35:0]      rem;
    logic [31:0]      root;
    logic [31:0]      b;
    logic [2:0][31:0] org;
    logic [2:0][17:0] dir;
    logic             miss;
  } sq_t;

  // clamp a wide signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [64:0] v);
    logic [31:0] r;
    if (v > $signed(65'sh0_7FFF_FFFF)) r = 32'h7FFF_FFFF;
    else if (v < -$signed(65'sh0_8000_0000)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // two result bits of the digit-by-digit square root
  function automatic sq_t sq_step(input sq_t a);
    sq_t         r;
    logic [35:0] rw;
    logic [35:0] trial;
    r = a;
    for (int k = 0; k < 2; k++) begin
      rw    = {r.rem[33:0], r.rad[63:62]};
      r.rad = {r.rad[61:0], 2'b00};
      trial = {2'b00, r.root, 2'b01};
      if (rw >= trial) begin
        r.rem  = rw - trial;
        r.root = {r.root[30:0], 1'b1};
      end else begin
        r.rem  = rw;
        r.root = {r.root[30:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ray_sphere_intersect.sv
// One ray per cycle while in_stall_o is low (it rises only when out_stall_i holds a
// full pipeline); the square root takes 16 of the stages, two root bits per stage,
// and sets the depth.
// Each stage advances when its successor is empty or moving, so bubbles close.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the
// register defaults.
`default_nettype none
module ray_sphere_intersect (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_idx_i,
  input  wire logic [31:0]          cfg_data_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire rsi_pkg::q32_t        origin_x_i,
  input  wire rsi_pkg::q32_t        origin_y_i,
  input  wire rsi_pkg::q32_t        origin_z_i,
  input  wire rsi_pkg::dir_t        dir_x_i,
  input  wire rsi_pkg::dir_t        dir_y_i,
  input  wire rsi_pkg::dir_t        dir_z_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [1:0]           status_o,
  output      logic [30:0]          distance_o,
  output      rsi_pkg::q32_t        hit_x_o,
  output      rsi_pkg::q32_t        hit_y_o,
  output      rsi_pkg::q32_t        hit_z_o,
  output      rsi_pkg::q32_t        normal_x_o,
  output      rsi_pkg::q32_t        normal_y_o,
  output      rsi_pkg::q32_t        normal_z_o
);
  import rsi_pkg::*;

  localparam int NSt  = 10 + SqrtStages;
  localparam int StT  = 5 + SqrtStages;
  localparam int StP  = StT + 1;
  localparam int StH  = StT + 2;
  localparam int StN  = StT + 3;
  localparam int StO  = StT + 4;

  // configuration registers
  logic [2:0][31:0] cen_q;
  logic [30:0]      rsq_q, rinv_q, far_q;
  logic [15:0]      eps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q  <= '0;
      rsq_q  <= 31'd16384;
      rinv_q <= 31'd131072;
      eps_q  <= 16'd66;
      far_q  <= 31'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CENTER_X:   cen_q[0] <= cfg_data_i;
        CFG_CENTER_Y:   cen_q[1] <= cfg_data_i;
        CFG_CENTER_Z:   cen_q[2] <= cfg_data_i;
        CFG_RADIUS_SQ:  rsq_q    <= cfg_data_i[30:0];
        CFG_RADIUS_INV: rinv_q   <= cfg_data_i[30:0];
        CFG_EPSILON:    eps_q    <= cfg_data_i[15:0];
        CFG_FAR:        far_q    <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage valids and enables: a stage loads when empty or when its successor loads
  logic [NSt-1:0] vld_q;
  logic [NSt-1:0] en;

  always_comb begin
    en[NSt-1] = !vld_q[NSt-1] || !out_stall_i;
    for (int k = NSt - 2; k >= 0; k--) en[k] = !vld_q[k] || en[k+1];
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NSt-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= in_valid_i;
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // ---------------- front: offset, dot products, discriminant
  logic [2:0][31:0] in_org;
  logic [2:0][17:0] in_dir;
  assign in_org = {origin_z_i, origin_y_i, origin_x_i};
  assign in_dir = {dir_z_i, dir_y_i, dir_x_i};

  logic [2:0][31:0] s1_op_d, s1_op_q, s1_org_q, s2_org_q, s3_org_q, s4_org_q;
  logic [2:0][17:0] s1_dir_q, s2_dir_q, s3_dir_q, s4_dir_q;
  logic [2:0][49:0] s2_pd_d, s2_pd_q;
  logic [2:0][62:0] s2_ps_d, s2_ps_q;
  logic [31:0]      s3_b_d, s3_b_q, s4_b_q;
  logic [63:0]      s3_neg_d, s3_neg_q, s4_neg_q;
  logic [51:0]      acc;
  logic [63:0]      sq_tmp;
  logic [62:0]      s4_bb_d, s4_bb_q;
  logic [63:0]      bb_full;
  logic [63:0]      pos;
  sq_t              s5_d, s5_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_op_d[i] = sat32(65'($signed(cen_q[i])) - 65'($signed(in_org[i])));
      s2_pd_d[i] = 50'($signed(s1_op_q[i]) * $signed(s1_dir_q[i]));
      sq_tmp     = 64'($signed(s1_op_q[i]) * $signed(s1_op_q[i]));
      s2_ps_d[i] = sq_tmp[62:0];
    end
    acc = 52'($signed(s2_pd_q[0])) + 52'($signed(s2_pd_q[1])) + 52'($signed(s2_pd_q[2]));
    s3_b_d   = sat32(65'($signed(acc[51:16])));
    s3_neg_d = 64'(s2_ps_q[0]) + 64'(s2_ps_q[1]) + 64'(s2_ps_q[2]);
    bb_full  = 64'($signed(s3_b_q) * $signed(s3_b_q));
    s4_bb_d  = bb_full[62:0];
    pos      = 64'(s4_bb_q) + 64'({rsq_q, 16'h0000});
    s5_d.miss = pos < s4_neg_q;
    s5_d.rad  = pos - s4_neg_q;
    s5_d.rem  = '0;
    s5_d.root = '0;
    s5_d.b    = s4_b_q;
    s5_d.org  = s4_org_q;
    s5_d.dir  = s4_dir_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      s1_op_q <= s1_op_d; s1_org_q <= in_org; s1_dir_q <= in_dir;
    end
    if (en[1]) begin
      s2_pd_q <= s2_pd_d; s2_ps_q <= s2_ps_d; s2_org_q <= s1_org_q; s2_dir_q <= s1_dir_q;
    end
    if (en[2]) begin
      s3_b_q <= s3_b_d; s3_neg_q <= s3_neg_d; s3_org_q <= s2_org_q; s3_dir_q <= s2_dir_q;
    end
    if (en[3]) begin
      s4_bb_q <= s4_bb_d; s4_neg_q <= s3_neg_q; s4_b_q <= s3_b_q;
      s4_org_q <= s3_org_q; s4_dir_q <= s3_dir_q;
    end
    if (en[4]) s5_q <= s5_d;
  end

  // ---------------- square root, two bits per stage
  sq_t sq_q [SqrtStages];

  for (genvar j = 0; j < SqrtStages; j++) begin : g_sqrt
    always_ff @(posedge clk_i) begin
      if (en[5 + j]) sq_q[j] <= sq_step((j == 0) ? s5_q : sq_q[(j == 0) ? 0 : j - 1]);
    end
  end

  // ---------------- back: root choice, hit point, normal
  sq_t              sq_last;
  logic signed [33:0] t1, t2, tsel;
  logic [30:0]      t_d, t_q, p_t_q, h_t_q, n_t_q;
  logic [1:0]       st_d, t_st_q, p_st_q, h_st_q, n_st_q;
  logic [2:0][31:0] t_org_q, p_org_q, h_hit_d, h_hit_q, n_hit_q, o_nrm_d;
  logic [2:0][17:0] t_dir_q;
  logic [2:0][49:0] p_prod_d, p_prod_q;
  logic [2:0][32:0] h_diff_d, h_diff_q;
  logic [2:0][64:0] n_prod_d, n_prod_q;
  logic [34:0]      hsum;
  logic [1:0]       o_st_q;
  logic [30:0]      o_t_q;
  logic [2:0][31:0] o_hit_q, o_nrm_q;

  assign sq_last = sq_q[SqrtStages-1];

  always_comb begin
    t1 = 34'($signed(sq_last.b)) - $signed({2'b00, sq_last.root});
    t2 = 34'($signed(sq_last.b)) + $signed({2'b00, sq_last.root});
    if (t1 > $signed({18'h0, eps_q})) begin
      tsel = t1; st_d = ST_HIT;
    end else if (t2 > $signed({18'h0, eps_q})) begin
      tsel = t2; st_d = ST_HIT;
    end else begin
      tsel = $signed({3'b000, far_q}); st_d = ST_BEHIND;
    end
    if (tsel > $signed(34'sh0_7FFF_FFFF)) t_d = 31'h7FFF_FFFF;
    else t_d = tsel[30:0];
    if (sq_last.miss) st_d = ST_MISS;

    for (int i = 0; i < 3; i++) begin
      p_prod_d[i] = 50'($signed({1'b0, t_q}) * $signed(t_dir_q[i]));
      hsum        = 35'($signed(p_org_q[i])) + 35'($signed(p_prod_q[i][49:16]));
      h_hit_d[i]  = sat32(65'($signed(hsum)));
      h_diff_d[i] = 33'($signed(h_hit_d[i])) - 33'($signed(cen_q[i]));
      n_prod_d[i] = 65'($signed(h_diff_q[i]) * $signed({1'b0, rinv_q}));
      o_nrm_d[i]  = sat32(65'($signed(n_prod_q[i][64:16])));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[StT]) begin
      t_q <= t_d; t_st_q <= st_d; t_org_q <= sq_last.org; t_dir_q <= sq_last.dir;
    end
    if (en[StP]) begin
      p_prod_q <= p_prod_d; p_t_q <= t_q; p_st_q <= t_st_q; p_org_q <= t_org_q;
    end
    if (en[StH]) begin
      h_hit_q <= h_hit_d; h_diff_q <= h_diff_d; h_t_q <= p_t_q; h_st_q <= p_st_q;
    end
    if (en[StN]) begin
      n_prod_q <= n_prod_d; n_hit_q <= h_hit_q; n_t_q <= h_t_q; n_st_q <= h_st_q;
    end
    // output register: zero everything on a miss
    if (en[StO]) begin
      o_st_q <= n_st_q;
      if (n_st_q == ST_MISS) begin
        o_t_q <= '0; o_hit_q <= '0; o_nrm_q <= '0;
      end else begin
        o_t_q <= n_t_q; o_hit_q <= n_hit_q; o_nrm_q <= o_nrm_d;
      end
    end
  end

  assign status_o   = o_st_q;
  assign distance_o = o_t_q;
  assign hit_x_o    = o_hit_q[0];
  assign hit_y_o    = o_hit_q[1];
  assign hit_z_o    = o_hit_q[2];
  assign normal_x_o = o_nrm_q[0];
  assign normal_y_o = o_nrm_q[1];
  assign normal_z_o = o_nrm_q[2];

`ifndef ASSERT_OFF
  // input side stalls only when every stage is full and the output is held
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && (&vld_q)))
    else $error("input stalled with room in the pipeline");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_MISS) |-> (distance_o == '0))
    else $error("miss with nonzero distance");

  // a front hit lies beyond epsilon
  a_hit_eps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_HIT) |-> (distance_o > {15'h0, eps_q}))
    else $error("hit distance not above epsilon");
`endif

endmodule
`default_nettype wire
